FILE: hdl/sdsc_pkg.sv
// Shared types, constants and helpers for the SD card SPI command sequencer.
`default_nettype none
package sdsc_pkg;

   localparam int DummyBytes = 10;
   localparam int RespTries  = 10;

   localparam logic [3:0] DUMMY_LIMIT  = 4'(DummyBytes);
   localparam logic [3:0] TRIES_RELOAD = 4'((RespTries > 1) ? (RespTries - 1) : 0);

   localparam logic [7:0] CMD0      = 8'h40;
   localparam logic [7:0] CMD1      = 8'h41;
   localparam logic [7:0] CMD8      = 8'h48;
   localparam logic [7:0] CMD12     = 8'h4C;
   localparam logic [7:0] CRC_CMD0  = 8'h95;
   localparam logic [7:0] CRC_CMD8  = 8'h87;
   localparam logic [7:0] CRC_NONE  = 8'h00;
   localparam logic [7:0] IDLE_BYTE = 8'hFF;
   localparam logic [7:0] R1_IDLE   = 8'h01;
   localparam logic [7:0] R1_READY  = 8'h00;

   localparam logic [3:0] CNT_ARG0 = 4'd1;
   localparam logic [3:0] CNT_ARG1 = 4'd2;
   localparam logic [3:0] CNT_ARG2 = 4'd3;
   localparam logic [3:0] CNT_ARG3 = 4'd4;
   localparam logic [3:0] CNT_CRC  = 4'd5;
   localparam logic [3:0] CNT_END  = 4'd6;

   typedef enum logic [1:0] {
      OP_INIT   = 2'd0,
      OP_CMD    = 2'd1,
      OP_XFER   = 2'd2,
      OP_SELECT = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_DUMMY,
      PH_DISCARD,
      PH_WAITRDY,
      PH_SEND,
      PH_STUFF,
      PH_POLL
   } phase_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  command_byte;
      logic [31:0] argument;
      logic [7:0]  received_byte;
      logic        select_level;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } hold_type;

   typedef struct packed {
      logic       transfer_request;
      logic [7:0] send_byte;
      logic       select_active;
      logic       busy_res;
      logic       done_res;
      logic [7:0] response;
      logic       card_mounted;
   } rsp_item_type;

   function automatic logic [7:0] crc_for(input logic [7:0] cmd);
      logic [7:0] crc;
      crc = CRC_NONE;
      if (cmd == CMD0) crc = CRC_CMD0;
      if (cmd == CMD8) crc = CRC_CMD8;
      return crc;
   endfunction

   function automatic logic [7:0] arg_byte(input logic [31:0] arg, input logic [3:0] cnt);
      logic [7:0] b;
      case (cnt)
         CNT_ARG0: b = arg[31:24];
         CNT_ARG1: b = arg[23:16];
         CNT_ARG2: b = arg[15:8];
         default:  b = arg[7:0];
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/sdsc_if.sv
// Request and response channel interfaces of the SD card SPI command sequencer.
`default_nettype none
interface sdsc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  command_byte;
   logic [31:0] argument;
   logic [7:0]  received_byte;
   logic        select_level;

   modport source (output valid, opcode, command_byte, argument, received_byte, select_level,
                   input ready);
   modport sink   (input valid, opcode, command_byte, argument, received_byte, select_level,
                   output ready);
endinterface

interface sdsc_rsp_if;
   logic       valid;
   logic       ready;
   logic       transfer_request;
   logic [7:0] send_byte;
   logic       select_active;
   logic       busy_res;
   logic       done_res;
   logic [7:0] response;
   logic       card_mounted;

   modport source (output valid, transfer_request, send_byte, select_active, busy_res,
                   done_res, response, card_mounted, input ready);
   modport sink   (input valid, transfer_request, send_byte, select_active, busy_res,
                   done_res, response, card_mounted, output ready);
endinterface
`default_nettype wire

FILE: hdl/sdsc_in_stage.sv
// Input register stage: holds one request transfer for the sequencer core.
`default_nettype none
module sdsc_in_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   sdsc_req_if.sink        req_chan,
   input  wire logic       advance,
   output sdsc_pkg::hold_type hold
);

   logic                    valid_ff, valid_in;
   sdsc_pkg::req_item_type  item_ff, item_in;
   logic                    take;

   assign take           = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (advance) valid_in = 1'b0;
      if (take) begin
         valid_in              = 1'b1;
         item_in.opcode        = req_chan.opcode;
         item_in.command_byte  = req_chan.command_byte;
         item_in.argument      = req_chan.argument;
         item_in.received_byte = req_chan.received_byte;
         item_in.select_level  = req_chan.select_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign hold = '{valid: valid_ff, item: item_ff};

endmodule
`default_nettype wire

FILE: hdl/sdsc_core.sv
// Sequencer core: card state, per-transfer control step and response register.
`default_nettype none
module sdsc_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire sdsc_pkg::hold_type hold,
   output logic               advance,
   sdsc_rsp_if.source         rsp_chan
);

   sdsc_pkg::phase_type  phase_ff, phase_in;
   logic [3:0]           count_ff, count_in;
   logic [3:0]           tries_ff, tries_in;
   logic [7:0]           cmd_ff, cmd_in;
   logic [31:0]          arg_ff, arg_in;
   logic                 init_ff, init_in;
   logic                 mounted_ff, mounted_in;
   logic                 select_ff, select_in;
   logic [7:0]           last_ff, last_in;

   logic                 out_valid_ff, out_valid_in;
   sdsc_pkg::rsp_item_type out_ff, out_in;

   sdsc_pkg::opcode_type op;
   sdsc_pkg::req_item_type it;
   logic                 idle;
   logic                 retry;
   logic                 xfer_req;
   logic [7:0]           xfer_byte;
   logic                 done_flag;

   assign it      = hold.item;
   assign op      = sdsc_pkg::opcode_type'(it.opcode);
   assign idle    = (phase_ff == sdsc_pkg::PH_IDLE);
   assign retry   = it.received_byte[7] && (tries_ff != 4'd0);
   assign advance = hold.valid && (!out_valid_ff || rsp_chan.ready);

   // next state
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      tries_in   = tries_ff;
      cmd_in     = cmd_ff;
      arg_in     = arg_ff;
      init_in    = init_ff;
      mounted_in = mounted_ff;
      select_in  = select_ff;
      last_in    = last_ff;
      unique case (op)
         sdsc_pkg::OP_INIT: begin
            if (idle) begin
               init_in   = 1'b1;
               select_in = 1'b0;
               phase_in  = sdsc_pkg::PH_DUMMY;
               count_in  = 4'd1;
            end
         end
         sdsc_pkg::OP_CMD: begin
            if (idle) begin
               cmd_in   = it.command_byte;
               arg_in   = it.argument;
               phase_in = sdsc_pkg::PH_DISCARD;
            end
         end
         sdsc_pkg::OP_SELECT: begin
            if (idle) select_in = it.select_level;
         end
         default: begin
            unique case (phase_ff)
               sdsc_pkg::PH_DUMMY: begin
                  if (count_ff < sdsc_pkg::DUMMY_LIMIT) begin
                     count_in = count_ff + 4'd1;
                  end else begin
                     select_in = 1'b1;
                     cmd_in    = sdsc_pkg::CMD0;
                     arg_in    = '0;
                     phase_in  = sdsc_pkg::PH_DISCARD;
                  end
               end
               sdsc_pkg::PH_DISCARD: phase_in = sdsc_pkg::PH_WAITRDY;
               sdsc_pkg::PH_WAITRDY: begin
                  if (it.received_byte == sdsc_pkg::IDLE_BYTE) begin
                     phase_in = sdsc_pkg::PH_SEND;
                     count_in = 4'd1;
                  end
               end
               sdsc_pkg::PH_SEND: begin
                  if (count_ff >= sdsc_pkg::CNT_ARG0 && count_ff <= sdsc_pkg::CNT_ARG3) begin
                     count_in = count_ff + 4'd1;
                  end else if (count_ff == sdsc_pkg::CNT_CRC) begin
                     count_in = sdsc_pkg::CNT_END;
                  end else if (cmd_ff == sdsc_pkg::CMD12) begin
                     phase_in = sdsc_pkg::PH_STUFF;
                  end else begin
                     phase_in = sdsc_pkg::PH_POLL;
                     tries_in = sdsc_pkg::TRIES_RELOAD;
                  end
               end
               sdsc_pkg::PH_STUFF: begin
                  phase_in = sdsc_pkg::PH_POLL;
                  tries_in = sdsc_pkg::TRIES_RELOAD;
               end
               sdsc_pkg::PH_POLL: begin
                  if (retry) begin
                     tries_in = tries_ff - 4'd1;
                  end else begin
                     last_in = it.received_byte;
                     if (!init_ff) begin
                        phase_in = sdsc_pkg::PH_IDLE;
                     end else if ((cmd_ff == sdsc_pkg::CMD0 &&
                                   it.received_byte == sdsc_pkg::R1_IDLE) ||
                                  (cmd_ff != sdsc_pkg::CMD0 &&
                                   it.received_byte != sdsc_pkg::R1_READY)) begin
                        cmd_in   = sdsc_pkg::CMD1;
                        arg_in   = '0;
                        phase_in = sdsc_pkg::PH_DISCARD;
                     end else begin
                        mounted_in = (cmd_ff != sdsc_pkg::CMD0);
                        select_in  = 1'b0;
                        init_in    = 1'b0;
                        phase_in   = sdsc_pkg::PH_IDLE;
                     end
                  end
               end
               default: ;
            endcase
         end
      endcase
   end

   // outputs of the step
   always_comb begin
      xfer_req  = 1'b0;
      xfer_byte = sdsc_pkg::IDLE_BYTE;
      done_flag = 1'b0;
      unique case (op)
         sdsc_pkg::OP_INIT, sdsc_pkg::OP_CMD: xfer_req = idle;
         sdsc_pkg::OP_SELECT: ;
         default: begin
            unique case (phase_ff)
               sdsc_pkg::PH_DUMMY, sdsc_pkg::PH_DISCARD, sdsc_pkg::PH_STUFF: xfer_req = 1'b1;
               sdsc_pkg::PH_WAITRDY: begin
                  xfer_req = 1'b1;
                  if (it.received_byte == sdsc_pkg::IDLE_BYTE) xfer_byte = cmd_ff;
               end
               sdsc_pkg::PH_SEND: begin
                  xfer_req = 1'b1;
                  if (count_ff >= sdsc_pkg::CNT_ARG0 && count_ff <= sdsc_pkg::CNT_ARG3) begin
                     xfer_byte = sdsc_pkg::arg_byte(arg_ff, count_ff);
                  end else if (count_ff == sdsc_pkg::CNT_CRC) begin
                     xfer_byte = sdsc_pkg::crc_for(cmd_ff);
                  end
               end
               sdsc_pkg::PH_POLL: begin
                  if (retry) begin
                     xfer_req = 1'b1;
                  end else if (!init_ff) begin
                     done_flag = 1'b1;
                  end else if ((cmd_ff == sdsc_pkg::CMD0 &&
                                it.received_byte == sdsc_pkg::R1_IDLE) ||
                               (cmd_ff != sdsc_pkg::CMD0 &&
                                it.received_byte != sdsc_pkg::R1_READY)) begin
                     xfer_req = 1'b1;
                  end else begin
                     done_flag = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      endcase
   end

   always_comb begin
      out_in                  = out_ff;
      out_valid_in            = out_valid_ff;
      if (rsp_chan.ready) out_valid_in = 1'b0;
      if (advance) begin
         out_valid_in            = 1'b1;
         out_in.transfer_request = xfer_req;
         out_in.send_byte        = xfer_byte;
         out_in.select_active    = select_in;
         out_in.busy_res         = (phase_in != sdsc_pkg::PH_IDLE);
         out_in.done_res         = done_flag;
         out_in.response         = last_in;
         out_in.card_mounted     = mounted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sdsc_pkg::PH_IDLE;
         count_ff     <= '0;
         tries_ff     <= '0;
         cmd_ff       <= '0;
         arg_ff       <= '0;
         init_ff      <= 1'b0;
         mounted_ff   <= 1'b0;
         select_ff    <= 1'b0;
         last_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            tries_ff   <= tries_in;
            cmd_ff     <= cmd_in;
            arg_ff     <= arg_in;
            init_ff    <= init_in;
            mounted_ff <= mounted_in;
            select_ff  <= select_in;
            last_ff    <= last_in;
         end
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.transfer_request = out_ff.transfer_request;
   assign rsp_chan.send_byte        = out_ff.send_byte;
   assign rsp_chan.select_active    = out_ff.select_active;
   assign rsp_chan.busy_res         = out_ff.busy_res;
   assign rsp_chan.done_res         = out_ff.done_res;
   assign rsp_chan.response         = out_ff.response;
   assign rsp_chan.card_mounted     = out_ff.card_mounted;

endmodule
`default_nettype wire

FILE: hdl/sd_spi_command_sequencer.sv
// Top level of the SD card SPI-mode command and init sequencer.
// Throughput: one request per cycle while responses are taken; input register,
// one step of control logic, response register, with ready passed back through
// both stages.
// Reset (synchronous, active high): idle, deselected, not mounted, response 0.
`default_nettype none
module sd_spi_command_sequencer (
   input wire logic   clock,
   input wire logic   reset,
   sdsc_req_if.sink   req_chan,
   sdsc_rsp_if.source rsp_chan
);

   sdsc_pkg::hold_type hold;
   logic               advance;

   sdsc_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .hold     (hold)
   );

   sdsc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .hold     (hold),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

   a_step_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_chan.valid)
      else $error("step taken but no response held");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.done_res |-> !rsp_chan.busy_res)
      else $error("done reported while still busy");

   a_xfer_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.transfer_request |-> rsp_chan.busy_res)
      else $error("byte transfer requested while idle");

   a_no_xfer_idle_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.transfer_request |-> rsp_chan.send_byte == sdsc_pkg::IDLE_BYTE)
      else $error("send byte not idle without transfer");

endmodule
`default_nettype wire

FILE: tb/tb_sd_spi_command_sequencer.sv
// Testbench for the SD card SPI command sequencer: predicted responses checked per transfer.
module tb_sd_spi_command_sequencer;

   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;

   logic clock;
   logic reset;

   sdsc_req_if req_bus ();
   sdsc_rsp_if rsp_bus ();

   sd_spi_command_sequencer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // predicted sequencer state
   sdsc_pkg::phase_type ph = sdsc_pkg::PH_IDLE;
   logic [3:0]  cnt     = '0;
   logic [3:0]  tries   = '0;
   logic [7:0]  hcmd    = '0;
   logic [31:0] harg    = '0;
   logic        init_on = 1'b0;
   logic        mounted = 1'b0;
   logic        sel     = 1'b0;
   logic [7:0]  last_r1 = '0;
   logic        xreq;
   logic [7:0]  xbyte;
   logic        fin;

   sdsc_pkg::rsp_item_type rsp_due_q[$];

   int  errors      = 0;
   int  n_sent      = 0;
   int  n_checked   = 0;
   int  n_done      = 0;
   int  n_timeouts  = 0;
   int  n_mounted   = 0;
   int  idle_cycles = 0;
   bit  req_gaps    = 1'b1;
   bit  rsp_gaps    = 1'b1;
   bit  hold_rsp    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void shift_out(logic [7:0] b);
      xreq  = 1'b1;
      xbyte = b;
   endfunction

   function automatic void issue_cmd(logic [7:0] c, logic [31:0] a);
      hcmd = c;
      harg = a;
      ph   = sdsc_pkg::PH_DISCARD;
      shift_out(sdsc_pkg::IDLE_BYTE);
   endfunction

   function automatic void arm_poll();
      ph    = sdsc_pkg::PH_POLL;
      tries = sdsc_pkg::TRIES_RELOAD;
      shift_out(sdsc_pkg::IDLE_BYTE);
   endfunction

   function automatic void close_init(logic m);
      mounted = m;
      sel     = 1'b0;
      init_on = 1'b0;
      ph      = sdsc_pkg::PH_IDLE;
      fin     = 1'b1;
   endfunction

   function automatic sdsc_pkg::rsp_item_type sequencer_step(sdsc_pkg::req_item_type it);
      sdsc_pkg::rsp_item_type r;
      logic         idle;
      logic [7:0]   rx;
      int           sh;
      idle  = (ph == sdsc_pkg::PH_IDLE);
      rx    = it.received_byte;
      xreq  = 1'b0;
      xbyte = sdsc_pkg::IDLE_BYTE;
      fin   = 1'b0;
      case (sdsc_pkg::opcode_type'(it.opcode))
         sdsc_pkg::OP_INIT: if (idle) begin
            init_on = 1'b1;
            sel     = 1'b0;
            ph      = sdsc_pkg::PH_DUMMY;
            cnt     = 4'd1;
            shift_out(sdsc_pkg::IDLE_BYTE);
         end
         sdsc_pkg::OP_CMD: if (idle) issue_cmd(it.command_byte, it.argument);
         sdsc_pkg::OP_XFER: if (!idle) begin
            case (ph)
               sdsc_pkg::PH_DUMMY: if (cnt < sdsc_pkg::DUMMY_LIMIT) begin
                  cnt = cnt + 4'd1;
                  shift_out(sdsc_pkg::IDLE_BYTE);
               end else begin
                  sel = 1'b1;
                  issue_cmd(sdsc_pkg::CMD0, 32'd0);
               end
               sdsc_pkg::PH_DISCARD: begin
                  ph = sdsc_pkg::PH_WAITRDY;
                  shift_out(sdsc_pkg::IDLE_BYTE);
               end
               sdsc_pkg::PH_WAITRDY: if (rx == sdsc_pkg::IDLE_BYTE) begin
                  ph  = sdsc_pkg::PH_SEND;
                  cnt = 4'd1;
                  shift_out(hcmd);
               end else begin
                  shift_out(sdsc_pkg::IDLE_BYTE);
               end
               sdsc_pkg::PH_SEND: if (cnt >= 4'd1 && cnt <= 4'd4) begin
                  sh  = 32 - 8 * int'(cnt);
                  cnt = cnt + 4'd1;
                  shift_out(harg[sh +: 8]);
               end else if (cnt == 4'd5) begin
                  cnt = 4'd6;
                  if (hcmd == sdsc_pkg::CMD0) shift_out(sdsc_pkg::CRC_CMD0);
                  else if (hcmd == sdsc_pkg::CMD8) shift_out(sdsc_pkg::CRC_CMD8);
                  else shift_out(sdsc_pkg::CRC_NONE);
               end else if (hcmd == sdsc_pkg::CMD12) begin
                  ph = sdsc_pkg::PH_STUFF;
                  shift_out(sdsc_pkg::IDLE_BYTE);
               end else begin
                  arm_poll();
               end
               sdsc_pkg::PH_STUFF: arm_poll();
               sdsc_pkg::PH_POLL: if (rx[7] && tries != 4'd0) begin
                  tries = tries - 4'd1;
                  shift_out(sdsc_pkg::IDLE_BYTE);
               end else begin
                  last_r1 = rx;
                  if (!init_on) begin
                     ph  = sdsc_pkg::PH_IDLE;
                     fin = 1'b1;
                  end else if (hcmd == sdsc_pkg::CMD0) begin
                     if (rx == sdsc_pkg::R1_IDLE) issue_cmd(sdsc_pkg::CMD1, 32'd0);
                     else close_init(1'b0);
                  end else if (rx == sdsc_pkg::R1_READY) begin
                     close_init(1'b1);
                  end else begin
                     issue_cmd(sdsc_pkg::CMD1, 32'd0);
                  end
               end
               default: ;
            endcase
         end
         sdsc_pkg::OP_SELECT: if (idle) sel = it.select_level;
      endcase
      r.transfer_request = xreq;
      r.send_byte        = xreq ? xbyte : sdsc_pkg::IDLE_BYTE;
      r.select_active    = sel;
      r.busy_res         = (ph != sdsc_pkg::PH_IDLE);
      r.done_res         = fin;
      r.response         = last_r1;
      r.card_mounted     = mounted;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         rsp_due_q.push_back(sequencer_step({req_bus.opcode, req_bus.command_byte,
                                             req_bus.argument, req_bus.received_byte,
                                             req_bus.select_level}));
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      sdsc_pkg::rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (rsp_due_q.size() == 0) begin
            $error("response transfer with nothing expected");
            errors++;
         end else begin
            want = rsp_due_q.pop_front();
            check_field("transfer_request", 32'(want.transfer_request),
                        32'(rsp_bus.transfer_request));
            check_field("send_byte", 32'(want.send_byte), 32'(rsp_bus.send_byte));
            check_field("select_active", 32'(want.select_active),
                        32'(rsp_bus.select_active));
            check_field("busy_res", 32'(want.busy_res), 32'(rsp_bus.busy_res));
            check_field("done_res", 32'(want.done_res), 32'(rsp_bus.done_res));
            check_field("response", 32'(want.response), 32'(rsp_bus.response));
            check_field("card_mounted", 32'(want.card_mounted), 32'(rsp_bus.card_mounted));
            n_checked++;
            if (want.done_res) begin
               n_done++;
               if (want.response[7]) n_timeouts++;
               if (want.card_mounted) n_mounted++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("tb_sd_spi_command_sequencer failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side pacing; a requested hold is counted here
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (rsp_gaps && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic sdsc_pkg::req_item_type rand_item(sdsc_pkg::opcode_type op);
      sdsc_pkg::req_item_type it;
      it.opcode        = op;
      it.command_byte  = 8'($urandom);
      it.argument      = $urandom;
      it.received_byte = 8'($urandom);
      it.select_level  = 1'($urandom);
      return it;
   endfunction

   task automatic send_req(sdsc_pkg::req_item_type it);
      int gap;
      gap = req_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= it.opcode;
      req_bus.command_byte  <= it.command_byte;
      req_bus.argument      <= it.argument;
      req_bus.received_byte <= it.received_byte;
      req_bus.select_level  <= it.select_level;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      n_sent++;
   endtask

   task automatic xfer(logic [7:0] rx);
      sdsc_pkg::req_item_type it;
      it = rand_item(sdsc_pkg::OP_XFER);
      it.received_byte = rx;
      send_req(it);
   endtask

   task automatic set_select(logic lvl);
      sdsc_pkg::req_item_type it;
      it = rand_item(sdsc_pkg::OP_SELECT);
      it.select_level = lvl;
      send_req(it);
   endtask

   // byte transfers of one command, from the discarded read to the R1 answer
   task automatic cmd_body(logic is12, int waits, int polls, logic [7:0] r1);
      xfer(8'($urandom));
      repeat (waits) xfer(8'($urandom_range(0, 254)));
      xfer(sdsc_pkg::IDLE_BYTE);
      repeat (6) xfer(8'($urandom));
      if (is12) xfer(8'($urandom));
      if (r1[7]) polls = 9;
      repeat (polls) xfer(8'($urandom) | 8'h80);
      xfer(r1);
   endtask

   task automatic do_command(logic [7:0] c, logic [31:0] a, int waits, int polls,
                             logic [7:0] r1);
      sdsc_pkg::req_item_type it;
      it = rand_item(sdsc_pkg::OP_CMD);
      it.command_byte = c;
      it.argument     = a;
      send_req(it);
      cmd_body(c == sdsc_pkg::CMD12, waits, polls, r1);
   endtask

   task automatic do_init(logic [7:0] cmd0_r1, int loops);
      send_req(rand_item(sdsc_pkg::OP_INIT));
      repeat (sdsc_pkg::DummyBytes) xfer(8'($urandom));
      cmd_body(1'b0, $urandom_range(0, 2), $urandom_range(0, 9), cmd0_r1);
      if (cmd0_r1 == sdsc_pkg::R1_IDLE) begin
         repeat (loops)
            cmd_body(1'b0, $urandom_range(0, 2), $urandom_range(0, 9),
                     ($urandom_range(0, 2) == 0) ? 8'h80 | 8'($urandom)
                                                 : sdsc_pkg::R1_IDLE);
         cmd_body(1'b0, $urandom_range(0, 2), $urandom_range(0, 9), sdsc_pkg::R1_READY);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (rsp_due_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_idle_ops();
      xfer(sdsc_pkg::IDLE_BYTE);
      set_select(1'b1);
      set_select(1'b0);
      set_select(1'b1);
   endtask

   // CMD12 with start and select while busy, a long not-ready wait and no answer;
   // then CMD8 with an all-ones argument
   task automatic test_command_cases();
      sdsc_pkg::req_item_type it;
      it = rand_item(sdsc_pkg::OP_CMD);
      it.command_byte = sdsc_pkg::CMD12;
      it.argument     = 32'd0;
      send_req(it);
      send_req(rand_item(sdsc_pkg::OP_INIT));
      send_req(rand_item(sdsc_pkg::OP_CMD));
      set_select(1'b0);
      cmd_body(1'b1, 20, 9, 8'hFF);
      do_command(sdsc_pkg::CMD8, 32'hFFFF_FFFF, 0, 0, sdsc_pkg::R1_READY);
   endtask

   task automatic test_init_sequences();
      do_init(sdsc_pkg::R1_IDLE, 2);
      do_init(8'h05, 0);
      do_init(sdsc_pkg::R1_IDLE, 0);
   endtask

   task automatic test_backpressure();
      drain();
      hold_rsp = 1'b1;
      req_gaps = 1'b0;
      do_command(sdsc_pkg::CMD1, $urandom, 2, 3, sdsc_pkg::R1_IDLE);
      drain();
      req_gaps = 1'b1;
   endtask

   task automatic test_random(int target);
      int          pick;
      logic [7:0]  c;
      logic [7:0]  r1;
      while (n_sent < target) begin
         if ($urandom_range(0, 24) == 0) begin
            req_gaps = ($urandom_range(0, 3) != 0);
            rsp_gaps = ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            case ($urandom_range(0, 4))
               0: c = sdsc_pkg::CMD0;
               1: c = sdsc_pkg::CMD8;
               2: c = sdsc_pkg::CMD12;
               3: c = sdsc_pkg::CMD1;
               default: c = 8'($urandom);
            endcase
            r1 = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
            do_command(c, $urandom,
                       ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                   : $urandom_range(0, 2),
                       $urandom_range(0, 9), r1);
         end else if (pick < 70) begin
            do_init(($urandom_range(0, 3) != 0) ? sdsc_pkg::R1_IDLE : 8'($urandom),
                    $urandom_range(0, 3));
         end else if (pick < 80) begin
            set_select(1'($urandom));
         end else if (pick < 90) begin
            send_req(rand_item(sdsc_pkg::opcode_type'($urandom_range(0, 3))));
         end else begin
            send_req(rand_item(sdsc_pkg::OP_CMD));
            repeat ($urandom_range(1, 8)) xfer(8'($urandom));
         end
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.opcode        <= sdsc_pkg::OP_INIT;
      req_bus.command_byte  <= '0;
      req_bus.argument      <= '0;
      req_bus.received_byte <= '0;
      req_bus.select_level  <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_idle_ops();
      test_command_cases();
      test_init_sequences();
      test_backpressure();
      test_random(800);

      drain();
      repeat (8) @(posedge clock);
      if (rsp_due_q.size() != 0) begin
         $error("%0d expected responses never arrived", rsp_due_q.size());
         errors++;
      end
      $display("Sent %0d requests and checked %0d responses.", n_sent, n_checked);
      $display("Saw %0d completions: %0d with no card answer, %0d with card mounted.",
               n_done, n_timeouts, n_mounted);
      if (errors == 0) begin
         $display("tb_sd_spi_command_sequencer passed");
      end else begin
         $display("tb_sd_spi_command_sequencer failed");
      end
      $finish;
   end

endmodule
